### hdl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, types and helpers of the bit-serial PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

    // Field widths
    localparam int unsigned DATA_W     = 16;
    localparam int unsigned FRAC_W     = 9;
    localparam int unsigned ACC_FRAC_W = 16;

    // Bit-serial multiplier: multiplicand x multiplier, one multiplier bit per cycle
    localparam int unsigned MCAND_W   = 32;
    localparam int unsigned MPLIER_W  = 18;
    localparam int unsigned PROD_W    = MCAND_W + MPLIER_W;
    localparam int unsigned MUL_STEPS = MPLIER_W;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);

    // Bit-serial restoring divider: one quotient bit per cycle
    localparam int unsigned DVD_W     = 56;
    localparam int unsigned DVS_W     = 16;
    localparam int unsigned DIV_STEPS = DVD_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Datapath accumulators
    localparam int unsigned SUM_W = 58;
    localparam int unsigned EXT_W = 50;
    localparam int unsigned ACC_W = 48;

    typedef logic signed [DATA_W-1:0] sdata_t;
    typedef logic        [DATA_W-1:0] udata_t;
    typedef logic        [MCAND_W-1:0] mcand_t;
    typedef logic        [MPLIER_W-1:0] mplier_t;
    typedef logic        [PROD_W-1:0] prod_t;
    typedef logic        [MUL_CNT_W-1:0] mul_cnt_t;
    typedef logic        [DVD_W-1:0] dvd_t;
    typedef logic        [DVS_W-1:0] dvs_t;
    typedef logic        [DIV_CNT_W-1:0] div_cnt_t;
    typedef logic        [SUM_W-1:0] sum_mag_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic signed [EXT_W-1:0] ext_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    // Derivative scale: 1000 ms per second times 256 for the Q8.8 gain
    localparam mplier_t DERIV_SCALE = 18'd256000;
    // Milliseconds per second, divisor of the integral increment
    localparam dvs_t    MS_DIVISOR  = 16'd1000;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Magnitude of a signed field word
    function automatic udata_t mag16(input sdata_t v);
        udata_t r;
        r = v[DATA_W-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

    // Magnitude of a one-bit-wider difference; the range keeps it within DATA_W bits
    function automatic udata_t mag17(input logic [DATA_W:0] v);
        logic [DATA_W:0] r;
        r = v[DATA_W] ? (~v + 1'b1) : v;
        return r[DATA_W-1:0];
    endfunction

    // Attach a sign to a magnitude
    function automatic sum_t apply_sign(input sum_mag_t m, input logic neg);
        sum_mag_t r;
        r = neg ? (~m + 1'b1) : m;
        return signed'(r);
    endfunction

endpackage

### hdl/pid_control_step.sv
// ----------------------------------------------------------------------------
// pid_control_step
// Fixed-point PID controller step with the derivative taken on the measurement.
// The input channel (s_valid/s_ready/s_measurement) takes one measured sample
// per word; the result channel (m_valid/m_ready/m_drive) returns one clamped
// drive word for each sample. Registers are written through cfg_we, cfg_index
// and cfg_wdata; the user must write them only while no sample is in flight,
// which the block itself does not enforce. The sequencer runs five products
// through the bit-serial multiplier and two quotients through the bit-serial
// divider, plus one of each per integral bound when gain_integ is nonzero.
// The input reopens as the result is loaded into the output register.
// Reset clears the integral and the last measurement and loads the register
// defaults. While the receiver stalls, the result waits in the output
// register; a further sample is accepted and computed meanwhile and holds in
// its last state until the output register frees.
// ----------------------------------------------------------------------------
module pid_control_step (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  pidc_pkg::sdata_t s_measurement,
    output logic             m_valid,
    input  logic             m_ready,
    output pidc_pkg::sdata_t m_drive
);

    typedef enum logic [2:0] {
        REG_TARGET_VALUE   = 3'd0,
        REG_DRIVE_MIN      = 3'd1,
        REG_DRIVE_MAX      = 3'd2,
        REG_PERIOD_MS      = 3'd3,
        REG_GAIN_PROP      = 3'd4,
        REG_GAIN_INTEG     = 3'd5,
        REG_GAIN_DERIV     = 3'd6,
        REG_INTEG_FRACTION = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_P, S_MUL_I1, S_MUL_I2, S_DIV_I, S_MUL_D1, S_MUL_D2, S_DIV_D,
        S_CLAMP_LO, S_CLAMP_HI, S_MUL_BL, S_DIV_BL, S_MUL_BH, S_DIV_BH, S_SAT, S_OUT
    } state_t;

    localparam pidc_pkg::sdata_t TargetRst    = 16'sd0;
    localparam pidc_pkg::sdata_t DriveMinRst  = 16'sh8000;
    localparam pidc_pkg::sdata_t DriveMaxRst  = 16'sh7FFF;
    localparam pidc_pkg::udata_t PeriodRst    = 16'd10;
    localparam pidc_pkg::sdata_t GainPropRst  = 16'sd256;
    localparam pidc_pkg::sdata_t GainIntegRst = 16'sd0;
    localparam pidc_pkg::sdata_t GainDerivRst = 16'sd0;
    localparam logic [pidc_pkg::FRAC_W-1:0] FracRst = 9'd256;
    localparam pidc_pkg::sum_t   RoundBias    = 58'sd65535;

    // Configuration registers
    pidc_pkg::sdata_t                target_reg, drive_min_reg, drive_max_reg;
    pidc_pkg::udata_t                period_reg;
    pidc_pkg::sdata_t                gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    logic [pidc_pkg::FRAC_W-1:0]     frac_reg;

    // Control and controller state
    state_t             state_reg, state_next;
    logic               mul_start_reg, mul_start_next;
    logic               div_start_reg, div_start_next;
    logic               m_valid_reg, m_valid_next;
    pidc_pkg::sdata_t   m_drive_reg, m_drive_next;
    pidc_pkg::acc_t     integral_reg, integral_next;
    pidc_pkg::sdata_t   prev_reg, prev_next;

    // Datapath
    pidc_pkg::sdata_t   meas_reg, meas_next;
    pidc_pkg::udata_t   err_mag_reg, err_mag_next;
    logic               err_neg_reg, err_neg_next;
    pidc_pkg::udata_t   dm_mag_reg, dm_mag_next;
    logic               dm_neg_reg, dm_neg_next;
    pidc_pkg::sum_t     sum_reg, sum_next;
    pidc_pkg::ext_t     acc_reg, acc_next;

    // Arithmetic units
    pidc_pkg::mcand_t   mul_mcand;
    pidc_pkg::mplier_t  mul_mplier;
    logic               mul_done;
    pidc_pkg::prod_t    mul_product;
    pidc_pkg::dvd_t     div_dividend;
    pidc_pkg::dvs_t     div_divisor;
    logic               div_done;
    pidc_pkg::dvd_t     div_quotient;

    logic [pidc_pkg::DATA_W:0] err_full, dm_full;
    pidc_pkg::udata_t   kp_mag, ki_mag, kd_mag, dmin_mag, dmax_mag, per_eff;
    logic               div_neg;
    pidc_pkg::sum_t     p_term, div_term, lo_drive, hi_drive, rnd_sum;
    pidc_pkg::ext_t     bound_term;
    pidc_pkg::sdata_t   drive_val;
    logic               ovf_pos, ovf_neg;

    pidc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_product)
    );

    pidc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg     <= TargetRst;
            drive_min_reg  <= DriveMinRst;
            drive_max_reg  <= DriveMaxRst;
            period_reg     <= PeriodRst;
            gain_prop_reg  <= GainPropRst;
            gain_integ_reg <= GainIntegRst;
            gain_deriv_reg <= GainDerivRst;
            frac_reg       <= FracRst;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TARGET_VALUE:   target_reg     <= cfg_wdata;
                REG_DRIVE_MIN:      drive_min_reg  <= cfg_wdata;
                REG_DRIVE_MAX:      drive_max_reg  <= cfg_wdata;
                REG_PERIOD_MS:      period_reg     <= cfg_wdata;
                REG_GAIN_PROP:      gain_prop_reg  <= cfg_wdata;
                REG_GAIN_INTEG:     gain_integ_reg <= cfg_wdata;
                REG_GAIN_DERIV:     gain_deriv_reg <= cfg_wdata;
                REG_INTEG_FRACTION: frac_reg       <= cfg_wdata[pidc_pkg::FRAC_W-1:0];
            endcase
        end
    end

    // Error and measurement change, with magnitudes for the serial units
    assign err_full = {target_reg[pidc_pkg::DATA_W-1], target_reg}
                    - {s_measurement[pidc_pkg::DATA_W-1], s_measurement};
    assign dm_full  = {s_measurement[pidc_pkg::DATA_W-1], s_measurement}
                    - {prev_reg[pidc_pkg::DATA_W-1], prev_reg};

    assign kp_mag   = pidc_pkg::mag16(gain_prop_reg);
    assign ki_mag   = pidc_pkg::mag16(gain_integ_reg);
    assign kd_mag   = pidc_pkg::mag16(gain_deriv_reg);
    assign dmin_mag = pidc_pkg::mag16(drive_min_reg);
    assign dmax_mag = pidc_pkg::mag16(drive_max_reg);
    // Treat a zero period as one millisecond
    assign per_eff  = (period_reg == '0) ? pidc_pkg::udata_t'(1) : period_reg;

    // Select multiplier operands for the current product
    always_comb begin
        unique case (state_reg)
            S_MUL_P: begin
                mul_mcand  = pidc_pkg::mcand_t'(err_mag_reg);
                mul_mplier = pidc_pkg::mplier_t'(kp_mag);
            end
            S_MUL_I1: begin
                mul_mcand  = pidc_pkg::mcand_t'(err_mag_reg);
                mul_mplier = pidc_pkg::mplier_t'(ki_mag);
            end
            S_MUL_I2: begin
                mul_mcand  = mul_product[pidc_pkg::MCAND_W-1:0];
                mul_mplier = pidc_pkg::mplier_t'(per_eff);
            end
            S_MUL_D1: begin
                mul_mcand  = pidc_pkg::mcand_t'(dm_mag_reg);
                mul_mplier = pidc_pkg::mplier_t'(kd_mag);
            end
            S_MUL_D2: begin
                mul_mcand  = mul_product[pidc_pkg::MCAND_W-1:0];
                mul_mplier = pidc_pkg::DERIV_SCALE;
            end
            S_MUL_BL: begin
                mul_mcand  = pidc_pkg::mcand_t'(dmin_mag);
                mul_mplier = pidc_pkg::mplier_t'(frac_reg);
            end
            S_MUL_BH: begin
                mul_mcand  = pidc_pkg::mcand_t'(dmax_mag);
                mul_mplier = pidc_pkg::mplier_t'(frac_reg);
            end
            default: begin
                mul_mcand  = '0;
                mul_mplier = '0;
            end
        endcase
    end

    // Select divider operands and the sign of the quotient
    always_comb begin
        unique case (state_reg)
            S_DIV_I: begin
                div_dividend = {mul_product[pidc_pkg::DVD_W-9:0], 8'h00};
                div_divisor  = pidc_pkg::MS_DIVISOR;
                div_neg      = gain_integ_reg[pidc_pkg::DATA_W-1] ^ err_neg_reg;
            end
            S_DIV_D: begin
                div_dividend = pidc_pkg::dvd_t'(mul_product);
                div_divisor  = per_eff;
                div_neg      = !gain_deriv_reg[pidc_pkg::DATA_W-1] ^ dm_neg_reg;
            end
            S_DIV_BL: begin
                div_dividend = pidc_pkg::dvd_t'({mul_product[24:0], 16'h0000});
                div_divisor  = ki_mag;
                div_neg      = drive_min_reg[pidc_pkg::DATA_W-1]
                             ^ gain_integ_reg[pidc_pkg::DATA_W-1];
            end
            S_DIV_BH: begin
                div_dividend = pidc_pkg::dvd_t'({mul_product[24:0], 16'h0000});
                div_divisor  = ki_mag;
                div_neg      = drive_max_reg[pidc_pkg::DATA_W-1]
                             ^ gain_integ_reg[pidc_pkg::DATA_W-1];
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
                div_neg      = 1'b0;
            end
        endcase
    end

    // Signed terms, bounds and the rounded drive
    assign p_term     = pidc_pkg::apply_sign(
                            pidc_pkg::sum_mag_t'({mul_product[pidc_pkg::MCAND_W-1:0], 8'h00}),
                            gain_prop_reg[pidc_pkg::DATA_W-1] ^ err_neg_reg);
    assign div_term   = pidc_pkg::apply_sign(pidc_pkg::sum_mag_t'(div_quotient), div_neg);
    assign bound_term = pidc_pkg::ext_t'(div_term);
    assign lo_drive   = pidc_pkg::sum_t'(signed'({drive_min_reg, 16'h0000}));
    assign hi_drive   = pidc_pkg::sum_t'(signed'({drive_max_reg, 16'h0000}));
    // Truncate toward zero: bias negative sums before the shift
    assign rnd_sum    = sum_reg + (sum_reg[pidc_pkg::SUM_W-1] ? RoundBias : '0);
    assign drive_val  = rnd_sum[pidc_pkg::ACC_FRAC_W +: pidc_pkg::DATA_W];
    assign ovf_pos    = !acc_reg[pidc_pkg::EXT_W-1]
                      && (acc_reg[pidc_pkg::EXT_W-2:pidc_pkg::ACC_W-1] != '0);
    assign ovf_neg    = acc_reg[pidc_pkg::EXT_W-1]
                      && (acc_reg[pidc_pkg::EXT_W-2:pidc_pkg::ACC_W-1] != '1);

    // Sequence one sample through the serial units
    always_comb begin
        state_next     = state_reg;
        mul_start_next = 1'b0;
        div_start_next = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_drive_next   = m_drive_reg;
        integral_next  = integral_reg;
        prev_next      = prev_reg;
        meas_next      = meas_reg;
        err_mag_next   = err_mag_reg;
        err_neg_next   = err_neg_reg;
        dm_mag_next    = dm_mag_reg;
        dm_neg_next    = dm_neg_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    meas_next      = s_measurement;
                    err_mag_next   = pidc_pkg::mag17(err_full);
                    err_neg_next   = err_full[pidc_pkg::DATA_W];
                    dm_mag_next    = pidc_pkg::mag17(dm_full);
                    dm_neg_next    = dm_full[pidc_pkg::DATA_W];
                    sum_next       = pidc_pkg::sum_t'(integral_reg);
                    state_next     = S_MUL_P;
                    mul_start_next = 1'b1;
                end
            end
            S_MUL_P: begin
                if (mul_done) begin
                    sum_next       = sum_reg + p_term;
                    state_next     = S_MUL_I1;
                    mul_start_next = 1'b1;
                end
            end
            S_MUL_I1: begin
                if (mul_done) begin
                    state_next     = S_MUL_I2;
                    mul_start_next = 1'b1;
                end
            end
            S_MUL_I2: begin
                if (mul_done) begin
                    state_next     = S_DIV_I;
                    div_start_next = 1'b1;
                end
            end
            S_DIV_I: begin
                if (div_done) begin
                    sum_next       = sum_reg + div_term;
                    acc_next       = pidc_pkg::ext_t'(integral_reg) + bound_term;
                    state_next     = S_MUL_D1;
                    mul_start_next = 1'b1;
                end
            end
            S_MUL_D1: begin
                if (mul_done) begin
                    state_next     = S_MUL_D2;
                    mul_start_next = 1'b1;
                end
            end
            S_MUL_D2: begin
                if (mul_done) begin
                    state_next     = S_DIV_D;
                    div_start_next = 1'b1;
                end
            end
            S_DIV_D: begin
                if (div_done) begin
                    sum_next   = sum_reg + div_term;
                    state_next = S_CLAMP_LO;
                end
            end
            // Lower bound first, so the upper bound wins when they cross
            S_CLAMP_LO: begin
                if (sum_reg < lo_drive) begin
                    sum_next = lo_drive;
                end
                state_next = S_CLAMP_HI;
            end
            S_CLAMP_HI: begin
                if (sum_reg > hi_drive) begin
                    sum_next = hi_drive;
                end
                if (gain_integ_reg != '0) begin
                    state_next     = S_MUL_BL;
                    mul_start_next = 1'b1;
                end else begin
                    state_next = S_SAT;
                end
            end
            S_MUL_BL: begin
                if (mul_done) begin
                    state_next     = S_DIV_BL;
                    div_start_next = 1'b1;
                end
            end
            S_DIV_BL: begin
                if (div_done) begin
                    if (acc_reg < bound_term) begin
                        acc_next = bound_term;
                    end
                    state_next     = S_MUL_BH;
                    mul_start_next = 1'b1;
                end
            end
            S_MUL_BH: begin
                if (mul_done) begin
                    state_next     = S_DIV_BH;
                    div_start_next = 1'b1;
                end
            end
            S_DIV_BH: begin
                if (div_done) begin
                    if (acc_reg > bound_term) begin
                        acc_next = bound_term;
                    end
                    state_next = S_SAT;
                end
            end
            // Saturate the integral to its stored width
            S_SAT: begin
                if (ovf_pos) begin
                    integral_next = pidc_pkg::ACC_MAX;
                end else if (ovf_neg) begin
                    integral_next = pidc_pkg::ACC_MIN;
                end else begin
                    integral_next = pidc_pkg::acc_t'(acc_reg);
                end
                prev_next  = meas_reg;
                state_next = S_OUT;
            end
            // Hold until the output register frees
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_drive_next = drive_val;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_drive_reg   <= '0;
            integral_reg  <= '0;
            prev_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            mul_start_reg <= mul_start_next;
            div_start_reg <= div_start_next;
            m_valid_reg   <= m_valid_next;
            m_drive_reg   <= m_drive_next;
            integral_reg  <= integral_next;
            prev_reg      <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        meas_reg    <= meas_next;
        err_mag_reg <= err_mag_next;
        err_neg_reg <= err_neg_next;
        dm_mag_reg  <= dm_mag_next;
        dm_neg_reg  <= dm_neg_next;
        sum_reg     <= sum_next;
        acc_reg     <= acc_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_drive = m_drive_reg;

`ifndef NO_ASSERTIONS
    // An accepted word closes the input until its result is out
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a word is in flight");

    // A result appears only from the output step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    // Multiplier completions land in a product step
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == S_MUL_P || state_reg == S_MUL_I1 ||
                      state_reg == S_MUL_I2 || state_reg == S_MUL_D1 ||
                      state_reg == S_MUL_D2 || state_reg == S_MUL_BL ||
                      state_reg == S_MUL_BH))
        else $error("multiplier finished outside a product step");

    // Divider completions land in a quotient step
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV_I || state_reg == S_DIV_D ||
                      state_reg == S_DIV_BL || state_reg == S_DIV_BH))
        else $error("divider finished outside a quotient step");
`endif

endmodule

### hdl/pidc_mul.sv
// ----------------------------------------------------------------------------
// pidc_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pidc_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  pidc_pkg::mcand_t  mcand,
    input  pidc_pkg::mplier_t mplier,
    output logic              done,
    output pidc_pkg::prod_t   product
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    pidc_pkg::mul_cnt_t         cnt_reg, cnt_next;
    pidc_pkg::mcand_t           mcand_reg;
    pidc_pkg::mcand_t           hi_reg;
    pidc_pkg::mplier_t          lo_reg;
    logic [pidc_pkg::MCAND_W:0] partial;

    // Add the multiplicand when the low multiplier bit is set
    assign partial = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    // Sequence the steps
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg == pidc_pkg::mul_cnt_t'(pidc_pkg::MUL_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift the partial sum down into the multiplier register
    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
        end else if (busy_reg) begin
            hi_reg <= partial[pidc_pkg::MCAND_W:1];
            lo_reg <= {partial[0], lo_reg[pidc_pkg::MPLIER_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

### hdl/pidc_div.sv
// ----------------------------------------------------------------------------
// pidc_div
// Bit-serial restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module pidc_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  pidc_pkg::dvd_t  dividend,
    input  pidc_pkg::dvs_t  divisor,
    output logic            done,
    output pidc_pkg::dvd_t  quotient
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    pidc_pkg::div_cnt_t         cnt_reg, cnt_next;
    pidc_pkg::dvs_t             dvs_reg;
    pidc_pkg::dvs_t             rem_reg;
    pidc_pkg::dvd_t             quo_reg;
    logic [pidc_pkg::DVS_W+1:0] diff;
    logic                       fits;

    // Trial subtract of the divisor from the shifted remainder
    assign diff = {1'b0, rem_reg, quo_reg[pidc_pkg::DVD_W-1]} - {2'b00, dvs_reg};
    assign fits = !diff[pidc_pkg::DVS_W+1];

    // Sequence the steps
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg == pidc_pkg::div_cnt_t'(pidc_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift dividend bits out at the top and quotient bits in at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[pidc_pkg::DVS_W-1:0]
                            : {rem_reg[pidc_pkg::DVS_W-2:0], quo_reg[pidc_pkg::DVD_W-1]};
            quo_reg <= {quo_reg[pidc_pkg::DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for the PID controller step. Measurement words go
// in over the input channel and every drive word that comes back is checked
// against a cycle-free model of the fixed-point PID law. The register set is
// swept through extremes and random settings, mostly while both channels stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned RUN_LIMIT      = 2_500_000;
    localparam int unsigned TAIL_CYCLES    = 400;
    localparam int unsigned RANDOM_PHASES  = 8;
    localparam int unsigned PHASE_SAMPLES  = 110;
    localparam int unsigned STREAM_SAMPLES = 120;
    localparam int unsigned PRINT_LIMIT    = 100;

    typedef enum logic [2:0] {
        REG_TARGET    = 3'd0,
        REG_DRIVE_MIN = 3'd1,
        REG_DRIVE_MAX = 3'd2,
        REG_PERIOD    = 3'd3,
        REG_GAIN_P    = 3'd4,
        REG_GAIN_I    = 3'd5,
        REG_GAIN_D    = 3'd6,
        REG_FRACTION  = 3'd7
    } reg_id_e;

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [2:0]       cfg_index;
    logic [15:0]      cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    pidc_pkg::sdata_t s_measurement;
    logic             m_valid;
    logic             m_ready;
    pidc_pkg::sdata_t m_drive;

    // Shadow copy of the register file
    pidc_pkg::sdata_t            target_r;
    pidc_pkg::sdata_t            drive_min_r;
    pidc_pkg::sdata_t            drive_max_r;
    pidc_pkg::udata_t            period_r;
    pidc_pkg::sdata_t            gain_p_r;
    pidc_pkg::sdata_t            gain_i_r;
    pidc_pkg::sdata_t            gain_d_r;
    logic [pidc_pkg::FRAC_W-1:0] fraction_r;

    // Controller state as the model sees it
    longint integ_state;
    longint last_meas;

    pidc_pkg::sdata_t pending_drive_q[$];
    bit               idle_on;
    int unsigned      cycle_count;
    int unsigned      samples_sent;
    int unsigned      words_checked;
    int unsigned      regs_written;
    int unsigned      mismatches;

    pid_control_step u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_measurement (s_measurement),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive       (m_drive)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Abort a run that hangs
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Timeout after %0d cycles, %0d drive words pending",
                     cycle_count, pending_drive_q.size());
            $display("pid_control_step regression: fail");
            $finish;
        end
    end

    function automatic longint clamp_range(input longint v, input longint lo,
                                           input longint hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    // Advance the controller by one measurement and return the drive it yields
    function automatic pidc_pkg::sdata_t predict_drive(input pidc_pkg::sdata_t meas_in);
        longint meas, tgt, dmin, dmax, per, kp, ki, kd, frac;
        longint err, p_term, i_step, d_term, sum, acc;
        meas = meas_in;
        tgt  = target_r;
        dmin = drive_min_r;
        dmax = drive_max_r;
        per  = period_r;
        kp   = gain_p_r;
        ki   = gain_i_r;
        kd   = gain_d_r;
        frac = fraction_r;
        if (per == 0) per = 1;

        err    = tgt - meas;
        p_term = kp * err * 256;
        i_step = ki * err * per * 256 / 1000;
        d_term = -kd * (meas - last_meas) * 1000 * 256 / per;

        sum = clamp_range(p_term + integ_state + i_step + d_term, dmin * 65536,
                          dmax * 65536);

        // Integral bounds only apply with a nonzero integral gain
        acc = integ_state + i_step;
        if (ki != 0)
            acc = clamp_range(acc, dmin * frac * 65536 / ki, dmax * frac * 65536 / ki);
        integ_state = clamp_range(acc, pidc_pkg::ACC_MIN, pidc_pkg::ACC_MAX);
        last_meas   = meas;
        return pidc_pkg::sdata_t'(sum / 65536);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    // Check each drive word against the oldest prediction
    always @(posedge aclk) begin : drive_check
        pidc_pkg::sdata_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_drive_q.size() == 0) begin
                report_mismatch($sformatf("drive word %0d with no sample pending", m_drive));
            end else begin
                want = pending_drive_q.pop_front();
                if (m_drive !== want)
                    report_mismatch($sformatf("drive word %0d: got %0d, expected %0d",
                                              words_checked, m_drive, want));
            end
            words_checked++;
        end
    end

    // Stall the result channel in random bursts
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
                m_ready = 1'b1;
            end
        end
    end

    task automatic write_reg(input reg_id_e idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_TARGET:    target_r    = value;
            REG_DRIVE_MIN: drive_min_r = value;
            REG_DRIVE_MAX: drive_max_r = value;
            REG_PERIOD:    period_r    = value;
            REG_GAIN_P:    gain_p_r    = value;
            REG_GAIN_I:    gain_i_r    = value;
            REG_GAIN_D:    gain_d_r    = value;
            REG_FRACTION:  fraction_r  = value[pidc_pkg::FRAC_W-1:0];
            default:       ;
        endcase
        regs_written++;
    endtask

    // Present one measurement word, with an occasional hold-off before it
    task automatic send_sample(input pidc_pkg::sdata_t meas);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_measurement = meas;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_drive_q.push_back(predict_drive(meas));
        samples_sent++;
    endtask

    // Drop valid and wait for every outstanding drive word
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_drive_q.size() != 0) @(posedge aclk);
    endtask

    // Register word biased toward the corners
    function automatic logic [15:0] pick_word();
        logic [31:0] r;
        case ($urandom_range(0, 5))
            0:       r = 32'h0000_8000;
            1:       r = 32'h0000_7FFF;
            2:       r = 32'h0;
            3, 4:    r = $urandom_range(0, 1023) - 512;
            default: r = $urandom;
        endcase
        return r[15:0];
    endfunction

    // Next measurement: mostly a walk, sometimes near the setpoint or a jump
    function automatic pidc_pkg::sdata_t next_measurement(input pidc_pkg::sdata_t prev_m);
        int v;
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 1) ? 32767 : -32768;
            1, 2:    v = int'(pidc_pkg::sdata_t'($urandom));
            3:       v = int'(target_r) + int'($urandom_range(0, 32)) - 16;
            default: v = int'(prev_m) + int'($urandom_range(0, 128)) - 64;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return pidc_pkg::sdata_t'(v);
    endfunction

    task automatic randomize_settings();
        logic [15:0] lo, hi, tmp, per;
        logic [31:0] r;
        lo = pick_word();
        hi = pick_word();
        // Keep the drive bounds in order most of the time
        if ($urandom_range(0, 7) != 0 && $signed(lo) > $signed(hi)) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        r   = $urandom_range(1, 100);
        per = $urandom_range(0, 1) ? r[15:0] : pick_word();
        r   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 511);
        write_reg(REG_TARGET, pick_word());
        write_reg(REG_DRIVE_MIN, lo);
        write_reg(REG_DRIVE_MAX, hi);
        write_reg(REG_PERIOD, per);
        write_reg(REG_GAIN_P, pick_word());
        write_reg(REG_GAIN_I, pick_word());
        write_reg(REG_GAIN_D, pick_word());
        write_reg(REG_FRACTION, r[15:0]);
    endtask

    task automatic test_default_settings();
        send_sample(16'sh0000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'shFFFF);
        send_sample(16'sh0001);
        send_sample(16'sh7FFF);
        drain_results();
    endtask

    task automatic test_extreme_gains();
        write_reg(REG_TARGET, 16'h7FFF);
        write_reg(REG_GAIN_P, 16'h8000);
        write_reg(REG_GAIN_D, 16'h7FFF);
        write_reg(REG_PERIOD, 16'h0001);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        drain_results();
        write_reg(REG_TARGET, 16'h8000);
        write_reg(REG_GAIN_P, 16'h7FFF);
        write_reg(REG_GAIN_I, 16'h8000);
        write_reg(REG_GAIN_D, 16'h8000);
        write_reg(REG_PERIOD, 16'hFFFF);
        write_reg(REG_FRACTION, 16'h0000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        drain_results();
    endtask

    task automatic test_special_cases();
        // Zero period counts as one millisecond
        write_reg(REG_TARGET, 16'h0000);
        write_reg(REG_PERIOD, 16'h0000);
        write_reg(REG_GAIN_P, 16'h0100);
        write_reg(REG_GAIN_I, 16'h0100);
        write_reg(REG_GAIN_D, 16'h0080);
        write_reg(REG_FRACTION, 16'h0100);
        send_sample(16'sd1000);
        send_sample(-16'sd1000);
        drain_results();

        // Inverted drive bounds: the upper bound wins
        write_reg(REG_DRIVE_MIN, 16'd100);
        write_reg(REG_DRIVE_MAX, 16'hFF9C);
        send_sample(16'sd5000);
        send_sample(-16'sd5000);
        drain_results();

        // Negative integral gain inverts the integral bounds; fraction above one,
        // written with junk above its top bit
        write_reg(REG_DRIVE_MIN, 16'h8000);
        write_reg(REG_DRIVE_MAX, 16'h7FFF);
        write_reg(REG_GAIN_I, 16'hFF00);
        write_reg(REG_FRACTION, 16'hFFFF);
        write_reg(REG_PERIOD, 16'd1000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        drain_results();

        // Zero integral gain leaves the integral unclamped
        write_reg(REG_GAIN_I, 16'h0000);
        send_sample(16'sd1234);
        drain_results();

        // Wind the integral into its bound, then pull it back
        write_reg(REG_GAIN_I, 16'h0040);
        write_reg(REG_GAIN_D, 16'h0000);
        write_reg(REG_PERIOD, 16'hFFFF);
        write_reg(REG_TARGET, 16'h7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        drain_results();
        write_reg(REG_TARGET, 16'h8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        drain_results();
    endtask

    task automatic test_random_settings();
        pidc_pkg::sdata_t meas;
        meas = '0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // One phase runs without any stalls
            idle_on = (phase != 3);
            randomize_settings();
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                meas = next_measurement(meas);
                send_sample(meas);
            end
            drain_results();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_steady_stream();
        pidc_pkg::sdata_t meas;
        meas    = '0;
        idle_on = 1'b0;
        randomize_settings();
        for (int n = 0; n < STREAM_SAMPLES; n++) begin
            meas = next_measurement(meas);
            send_sample(meas);
        end
        drain_results();
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_measurement = '0;
        idle_on       = 1'b1;
        samples_sent  = 0;
        words_checked = 0;
        regs_written  = 0;
        mismatches    = 0;

        // Register defaults and cleared state after reset
        target_r    = 16'sh0000;
        drive_min_r = 16'sh8000;
        drive_max_r = 16'sh7FFF;
        period_r    = 16'd10;
        gain_p_r    = 16'sh0100;
        gain_i_r    = 16'sh0000;
        gain_d_r    = 16'sh0000;
        fraction_r  = 9'd256;
        integ_state = 0;
        last_meas   = 0;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_default_settings();
        test_extreme_gains();
        test_special_cases();
        test_random_settings();
        test_steady_stream();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Ran %0d measurement words through %0d register writes, both channels stalled",
                 samples_sent, regs_written);
        $display("Checked %0d drive words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("pid_control_step regression: pass");
        end else begin
            $display("pid_control_step regression: fail");
        end
        $finish;
    end

endmodule
